// ===== rtl/elevator_car_door_sequencer_assert.svh =====
// assertion macros for the car and door sequencer
`ifndef ELEVATOR_CAR_DOOR_SEQUENCER_ASSERT_SVH
`define ELEVATOR_CAR_DOOR_SEQUENCER_ASSERT_SVH

// same-cycle implication, reset disables the check
`define ECDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset disables the check
`define ECDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ecds_pkg.sv =====
// ----------------------------------------------------------------------------
// ecds_pkg
// types, constants and code helpers shared by the car and door sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecds_pkg;

  // building size
  localparam int unsigned FLOORS   = 16;
  localparam int unsigned FLOOR_W  = $clog2(FLOORS);
  localparam int unsigned TARGET_W = 4;
  // common width for floor/target compares
  localparam int unsigned CMP_W    = (FLOOR_W > TARGET_W) ? FLOOR_W : TARGET_W;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WAIT_W   = 20;
  localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(3000);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // car state codes as seen on the result word
  localparam logic [2:0] CODE_IDLE    = 3'd0;
  localparam logic [2:0] CODE_UP      = 3'd1;
  localparam logic [2:0] CODE_DOWN    = 3'd2;
  localparam logic [2:0] CODE_OPENING = 3'd3;
  localparam logic [2:0] CODE_WAITING = 3'd4;
  localparam logic [2:0] CODE_CLOSING = 3'd5;

  // motor commands
  localparam logic [1:0] LIFT_NONE  = 2'd0;
  localparam logic [1:0] LIFT_UP    = 2'd1;
  localparam logic [1:0] LIFT_DOWN  = 2'd2;
  localparam logic [1:0] DOOR_NONE  = 2'd0;
  localparam logic [1:0] DOOR_OPEN  = 2'd1;
  localparam logic [1:0] DOOR_CLOSE = 2'd2;

  localparam logic SEL_DOOR = 1'b0;
  localparam logic SEL_LIFT = 1'b1;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_UP      = 6'b000010,
    MODE_DOWN    = 6'b000100,
    MODE_OPENING = 6'b001000,
    MODE_WAITING = 6'b010000,
    MODE_CLOSING = 6'b100000
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [FLOOR_W-1:0] floor_num;
    logic               moving;
    logic [TIME_W-1:0]  wait_start;
    logic               last_select;
  } car_state_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_floor;
    logic                obstacle;
    logic                floor_arrived;
    logic                door_done;
    logic [TIME_W-1:0]   now_ms;
  } tick_t;

  typedef struct packed {
    logic [2:0] car_state;
    logic [3:0] floor_now;
    logic       moving;
    logic       motor_select;
    logic [1:0] lift_drive;
    logic [1:0] door_drive;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_UP:      code = CODE_UP;
      MODE_DOWN:    code = CODE_DOWN;
      MODE_OPENING: code = CODE_OPENING;
      MODE_WAITING: code = CODE_WAITING;
      MODE_CLOSING: code = CODE_CLOSING;
      default:      code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ecds_step.sv =====
// ----------------------------------------------------------------------------
// ecds_step
// next-state and result logic for one control tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecds_step (
  input  ecds_pkg::car_state_t         cur_i,
  input  ecds_pkg::tick_t              tick_i,
  input  logic [ecds_pkg::WAIT_W-1:0]  door_wait_i,
  output ecds_pkg::car_state_t         nxt_o,
  output ecds_pkg::result_t            res_o
);

  localparam logic [ecds_pkg::FLOOR_W-1:0] TopFloor =
    ecds_pkg::FLOOR_W'(ecds_pkg::FLOORS - 1);

  logic [ecds_pkg::FLOOR_W-1:0] floor_up;
  logic [ecds_pkg::FLOOR_W-1:0] floor_dn;
  logic [ecds_pkg::FLOOR_W-1:0] floor_sel;
  logic [ecds_pkg::CMP_W-1:0]   tgt_ext;
  logic [ecds_pkg::CMP_W-1:0]   flr_ext;
  logic [ecds_pkg::CMP_W-1:0]   nxt_flr_ext;
  logic [ecds_pkg::TIME_W-1:0]  elapsed;
  logic                         wait_over;
  logic [1:0]                   lift;
  logic [1:0]                   door;
  ecds_pkg::car_state_t         nxt;

  // saturating floor steps
  assign floor_up = (cur_i.floor_num < TopFloor) ? cur_i.floor_num + 1'b1 : cur_i.floor_num;
  assign floor_dn = (cur_i.floor_num != '0) ? cur_i.floor_num - 1'b1 : cur_i.floor_num;

  assign tgt_ext = ecds_pkg::CMP_W'(tick_i.target_floor);

  // elapsed time wraps modulo 2^32
  assign elapsed   = tick_i.now_ms - cur_i.wait_start;
  assign wait_over = elapsed >= ecds_pkg::TIME_W'(door_wait_i);

  always_comb begin
    nxt       = cur_i;
    lift      = ecds_pkg::LIFT_NONE;
    door      = ecds_pkg::DOOR_NONE;
    floor_sel = cur_i.floor_num;
    unique case (cur_i.mode)
      ecds_pkg::MODE_UP: begin
        nxt.last_select = ecds_pkg::SEL_LIFT;
        lift            = ecds_pkg::LIFT_UP;
        floor_sel       = floor_up;
      end
      ecds_pkg::MODE_DOWN: begin
        nxt.last_select = ecds_pkg::SEL_LIFT;
        lift            = ecds_pkg::LIFT_DOWN;
        floor_sel       = floor_dn;
      end
      ecds_pkg::MODE_OPENING: begin
        nxt.last_select = ecds_pkg::SEL_DOOR;
        door            = ecds_pkg::DOOR_OPEN;
        if (tick_i.door_done) nxt.mode = ecds_pkg::MODE_IDLE;
      end
      ecds_pkg::MODE_WAITING: begin
        if (tick_i.obstacle) begin
          nxt.wait_start = tick_i.now_ms;
        end else if (wait_over) begin
          nxt.mode = ecds_pkg::MODE_CLOSING;
        end
      end
      ecds_pkg::MODE_CLOSING: begin
        nxt.last_select = ecds_pkg::SEL_DOOR;
        door            = ecds_pkg::DOOR_CLOSE;
        if (tick_i.obstacle) nxt.mode = ecds_pkg::MODE_OPENING;
      end
      default: begin
        nxt.mode = ecds_pkg::MODE_IDLE;
        if (tgt_ext != ecds_pkg::CMP_W'(cur_i.floor_num)) begin
          nxt.wait_start = tick_i.now_ms;
          nxt.mode       = ecds_pkg::MODE_WAITING;
        end
      end
    endcase

    flr_ext = ecds_pkg::CMP_W'(floor_sel);

    // floor-reached rule: arrival while traveling, or close done
    if ((((cur_i.mode == ecds_pkg::MODE_UP) || (cur_i.mode == ecds_pkg::MODE_DOWN))
         && tick_i.floor_arrived)
        || ((cur_i.mode == ecds_pkg::MODE_CLOSING) && tick_i.door_done)) begin
      nxt.floor_num = floor_sel;
      if (tgt_ext < flr_ext) begin
        nxt.moving = 1'b1;
        nxt.mode   = ecds_pkg::MODE_DOWN;
      end else if (tgt_ext > flr_ext) begin
        nxt.moving = 1'b1;
        nxt.mode   = ecds_pkg::MODE_UP;
      end else begin
        nxt.moving = 1'b0;
        nxt.mode   = ecds_pkg::MODE_OPENING;
      end
    end
  end

  assign nxt_flr_ext = ecds_pkg::CMP_W'(nxt.floor_num);

  assign nxt_o              = nxt;
  assign res_o.car_state    = ecds_pkg::mode_code(nxt.mode);
  assign res_o.floor_now    = nxt_flr_ext[3:0];
  assign res_o.moving       = nxt.moving;
  assign res_o.motor_select = nxt.last_select;
  assign res_o.lift_drive   = lift;
  assign res_o.door_drive   = door;

endmodule

`default_nettype wire

// ===== rtl/elevator_car_door_sequencer.sv =====
// flow: an accepted word waits in the input register, then passes the state update
// into the result register; one word per cycle while the result side takes words,
// a rate set by the single-pass state update
// reset: rst_ni low clears the car to idle at floor 0, drops both valid flags
// and loads the door wait time with 3000 ms; no clearing pass is needed
// ----------------------------------------------------------------------------
// elevator_car_door_sequencer
// car and door state machine stepped once per control tick word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "elevator_car_door_sequencer_assert.svh"

module elevator_car_door_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // door wait time register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ecds_pkg::WAIT_W-1:0]       cfg_data_i,

  // tick words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] target_floor, [4] obstacle, [5] floor_arrived, [6] door_done,
  // [38:7] now_ms, [39] zero
  input  logic [ecds_pkg::IN_DATA_W-1:0]    s_axis_tdata,

  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] car_state, [6:3] floor_now, [7] moving, [8] motor_select,
  // [10:9] lift_drive, [12:11] door_drive, [15:13] zero
  output logic [ecds_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  // configuration register, always writable
  logic [ecds_pkg::WAIT_W-1:0] door_wait_q;

  // input register
  logic              in_valid_q;
  ecds_pkg::tick_t   tick_q;

  // result register
  logic              out_valid_q;
  ecds_pkg::result_t res_q;

  // car state
  ecds_pkg::car_state_t state_q;
  ecds_pkg::car_state_t state_d;
  ecds_pkg::result_t    res_d;

  logic out_free;
  logic advance;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  // the result register frees up when empty or drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  // the held tick is processed as it moves into the result register
  assign advance       = in_valid_q && out_free;
  // the input register takes a new word when empty or emptying
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_wait_q <= ecds_pkg::WAIT_RESET;
    end else if (cfg_valid_i) begin
      door_wait_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // unpack the tick word into the input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q.target_floor  <= s_axis_tdata[3:0];
      tick_q.obstacle      <= s_axis_tdata[4];
      tick_q.floor_arrived <= s_axis_tdata[5];
      tick_q.door_done     <= s_axis_tdata[6];
      tick_q.now_ms        <= s_axis_tdata[38:7];
    end
  end

  ecds_step u_step (
    .cur_i       (state_q),
    .tick_i      (tick_q),
    .door_wait_i (door_wait_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // state moves only when a tick is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= ecds_pkg::MODE_IDLE;
      state_q.floor_num   <= '0;
      state_q.moving      <= 1'b0;
      state_q.wait_start  <= '0;
      state_q.last_select <= ecds_pkg::SEL_DOOR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.door_drive, res_q.lift_drive, res_q.motor_select,
                          res_q.moving, res_q.floor_now, res_q.car_state};

  // lift commands only go out with the lift motor selected
  `ECDS_ASSERT_NOW(a_lift_sel, clk_i, rst_ni,
    out_valid_q && (res_q.lift_drive != ecds_pkg::LIFT_NONE),
    res_q.motor_select == ecds_pkg::SEL_LIFT)

  // never drive lift and door in the same tick
  `ECDS_ASSERT_NOW(a_one_motor, clk_i, rst_ni, out_valid_q,
    (res_q.lift_drive == ecds_pkg::LIFT_NONE) || (res_q.door_drive == ecds_pkg::DOOR_NONE))

  // moving flag tracks the travel states
  `ECDS_ASSERT_NOW(a_moving, clk_i, rst_ni, 1'b1,
    state_q.moving == ((state_q.mode == ecds_pkg::MODE_UP) ||
                       (state_q.mode == ecds_pkg::MODE_DOWN)))

  // a stalled result holds the held tick back
  `ECDS_ASSERT_NEXT(a_hold, clk_i, rst_ni,
    in_valid_q && out_valid_q && !m_axis_tready, in_valid_q && $stable(state_q))

endmodule

`default_nettype wire

// ===== tb/sv/ecds_car_checker.sv =====
// ----------------------------------------------------------------------------
// ecds_car_checker
// watches the register, tick and result channels of the car and door
// sequencer, steps its own copy of the car state for every accepted tick word
// and compares each result word against the oldest predicted status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecds_car_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ecds_pkg::WAIT_W-1:0]    cfg_data_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [ecds_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [ecds_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                             mismatch_count_o,
  output int                             pending_count_o,
  output int                             checked_count_o,
  output logic [7:0]                     states_seen_o
);

  import ecds_pkg::*;

  // result word layout, lowest bits last
  typedef struct packed {
    logic [2:0] pad;
    logic [1:0] door_drive;
    logic [1:0] lift_drive;
    logic       motor_select;
    logic       moving;
    logic [3:0] floor_now;
    logic [2:0] car_state;
  } car_status_t;

  logic [WAIT_W-1:0]  door_wait;
  logic [2:0]         car_mode;
  logic [FLOOR_W-1:0] car_floor;
  logic               car_moving;
  logic [TIME_W-1:0]  wait_began;
  logic               motor_sel;

  car_status_t car_status_q[$];
  int          mismatches;
  int          checked;
  logic [7:0]  seen;

  function automatic void settle_at_floor(input logic [TARGET_W-1:0] target);
    if (target < car_floor) begin
      car_moving = 1'b1;
      car_mode   = CODE_DOWN;
    end else if (target > car_floor) begin
      car_moving = 1'b1;
      car_mode   = CODE_UP;
    end else begin
      car_moving = 1'b0;
      car_mode   = CODE_OPENING;
    end
  endfunction

  task automatic step_car(input logic [IN_DATA_W-1:0] word, output car_status_t status);
    logic [TARGET_W-1:0] target;
    logic                obstacle;
    logic                arrived;
    logic                done;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   elapsed;
    logic [1:0]          lift;
    logic [1:0]          door;
    target   = word[3:0];
    obstacle = word[4];
    arrived  = word[5];
    done     = word[6];
    now      = word[38:7];
    lift     = LIFT_NONE;
    door     = DOOR_NONE;
    case (car_mode)
      CODE_UP: begin
        motor_sel = SEL_LIFT;
        lift      = LIFT_UP;
        if (arrived) begin
          if (car_floor < FLOORS - 1) car_floor = car_floor + 1'b1;
          settle_at_floor(target);
        end
      end
      CODE_DOWN: begin
        motor_sel = SEL_LIFT;
        lift      = LIFT_DOWN;
        if (arrived) begin
          if (car_floor > 0) car_floor = car_floor - 1'b1;
          settle_at_floor(target);
        end
      end
      CODE_OPENING: begin
        motor_sel = SEL_DOOR;
        door      = DOOR_OPEN;
        if (done) car_mode = CODE_IDLE;
      end
      CODE_WAITING: begin
        elapsed = now - wait_began;
        if (obstacle) wait_began = now;
        else if (elapsed >= TIME_W'(door_wait)) car_mode = CODE_CLOSING;
      end
      CODE_CLOSING: begin
        motor_sel = SEL_DOOR;
        door      = DOOR_CLOSE;
        if (obstacle) car_mode = CODE_OPENING;
        // close done beats the obstacle reopen
        if (done) settle_at_floor(target);
      end
      default: begin
        car_mode = CODE_IDLE;
        if (target != car_floor) begin
          wait_began = now;
          car_mode   = CODE_WAITING;
        end
      end
    endcase
    status.pad          = 3'b000;
    status.door_drive   = door;
    status.lift_drive   = lift;
    status.motor_select = motor_sel;
    status.moving       = car_moving;
    status.floor_now    = 4'(car_floor);
    status.car_state    = car_mode;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    car_status_t predicted;
    car_status_t observed;
    if (!rst_ni) begin
      door_wait  = WAIT_RESET;
      car_mode   = CODE_IDLE;
      car_floor  = '0;
      car_moving = 1'b0;
      wait_began = '0;
      motor_sel  = SEL_DOOR;
      car_status_q.delete();
      mismatches = 0;
      checked    = 0;
      seen       = '0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      checked_count_o  <= 0;
      states_seen_o    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) door_wait = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        step_car(s_tdata_i, predicted);
        car_status_q.push_back(predicted);
        seen[car_mode] = 1'b1;
      end
      if (m_tvalid_i && m_tready_i) begin
        observed = car_status_t'(m_tdata_i);
        if (car_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %h arrived with no tick waiting", m_tdata_i);
        end else begin
          predicted = car_status_q.pop_front();
          checked++;
          if (observed != predicted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d: expected state %0d floor %0d moving %b sel %b lift %0d door %0d pad %0d",
                       checked, predicted.car_state, predicted.floor_now, predicted.moving,
                       predicted.motor_select, predicted.lift_drive, predicted.door_drive,
                       predicted.pad);
              $display("  actual state %0d floor %0d moving %b sel %b lift %0d door %0d pad %0d",
                       observed.car_state, observed.floor_now, observed.moving,
                       observed.motor_select, observed.lift_drive, observed.door_drive,
                       observed.pad);
            end
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= car_status_q.size();
      checked_count_o  <= checked;
      states_seen_o    <= seen;
    end
  end

endmodule

// ===== tb/sv/tb_elevator_car_door_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_elevator_car_door_sequencer
// drives control tick words into the car and door sequencer under several
// door wait settings, with random gaps on both streams and one long result
// stall, while a checker predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elevator_car_door_sequencer;

  import ecds_pkg::*;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int HOLD_OFF_CYCLES = 300;
  // longest quiet stretch: the result hold-off plus a long gap, many times over
  localparam int WATCHDOG_LIMIT  = 5000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [WAIT_W-1:0]     cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int         mismatch_count;
  int         pending_count;
  int         checked_count;
  logic [7:0] states_seen;

  // sender-side bookkeeping
  logic                hold_off_go = 1'b0;
  int                  quiet_left  = 0;
  int                  ticks_sent  = 0;
  int                  settings_used = 1;
  int                  idle_cycles = 0;
  logic [TARGET_W-1:0] plan_target = '0;
  logic [TIME_W-1:0]   clock_ms    = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  elevator_car_door_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ecds_car_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count),
    .states_seen_o    (states_seen)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one tick word and hold it until the block takes it
  task automatic send_tick(input logic [TARGET_W-1:0] target, input logic obstacle,
                           input logic arrived, input logic done,
                           input logic [TIME_W-1:0] now, input bit no_gaps);
    int gap;
    gap = (no_gaps || quiet_left > 0) ? 0 : pick_gap();
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 99) < 3) quiet_left = 30;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    // [3:0] target, [4] obstacle, [5] arrived, [6] done, [38:7] now, [39] zero
    s_axis_tdata  <= {1'b0, now, done, arrived, obstacle, target};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // stop offering ticks and wait for every predicted result word
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // door wait register write, only with the block idle
  task automatic write_door_wait(input logic [WAIT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one tick from a planner that holds its target for a while and a clock
  // that moves on in steps scaled to the door wait, plus some pure noise
  task automatic random_tick(input int unsigned wait_ms, input bit no_gaps);
    int                r;
    logic [TIME_W-1:0] step;
    logic              obstacle;
    logic              arrived;
    logic              done;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, no_gaps);
    end else begin
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 3))
          0:       plan_target = '0;
          1:       plan_target = 4'd15;
          default: plan_target = 4'($urandom_range(0, 15));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // long enough to run out the door wait
        step     = wait_ms + $urandom_range(0, wait_ms / 2 + 5);
        clock_ms = clock_ms + step;
      end else if (r < 13) begin
        // park the clock just below the wrap
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, wait_ms + 8);
      end else begin
        step     = $urandom_range(0, wait_ms / 3 + 2);
        clock_ms = clock_ms + step;
      end
      obstacle = ($urandom_range(0, 99) < 12);
      arrived  = ($urandom_range(0, 99) < 35);
      done     = ($urandom_range(0, 99) < 35);
      send_tick(plan_target, obstacle, arrived, done, clock_ms, no_gaps);
    end
  endtask

  task automatic run_phase(input int unsigned wait_ms, input bit pressure);
    // under pressure the sender keeps offering while the result side holds off
    if (pressure) hold_off_go <= 1'b1;
    for (int i = 0; i < ITEMS_PER_PHASE; i++)
      random_tick(wait_ms, pressure && i < 100);
  endtask

  // result side: random ready, quiet stretches, and the one long hold-off
  initial begin : result_sink
    bit hold_off_used;
    int gap;
    hold_off_used = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_go && !hold_off_used) begin
        hold_off_used = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 3) begin
        m_axis_tready <= 1'b1;
        repeat (40) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        m_axis_tready <= (gap == 0);
        repeat (gap == 0 ? 1 : gap) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles in a row with no word moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, pending_count);
        $display("tb_elevator_car_door_sequencer failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WAIT_W-1:0] odd_wait;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk with the reset door wait of 3000 ms
    send_tick(4'd0,  1'b0, 1'b0, 1'b0, 32'd0,          1'b0); // idle at own floor
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'hFFFF_F000,  1'b0); // call starts the wait
    send_tick(4'd2,  1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0); // obstacle restarts it
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'd100,        1'b0); // time wrapped, short
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'd3000,       1'b0); // timeout across wrap
    send_tick(4'd2,  1'b1, 1'b0, 1'b0, 32'd3001,       1'b0); // obstacle reopens
    send_tick(4'd2,  1'b0, 1'b0, 1'b1, 32'd3002,       1'b0); // open done
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'd3003,       1'b0); // wait again
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'd6002,       1'b0); // one ms short
    send_tick(4'd2,  1'b0, 1'b0, 1'b0, 32'd6003,       1'b0); // exactly the wait
    send_tick(4'd2,  1'b1, 1'b0, 1'b1, 32'd6004,       1'b0); // close done beats obstacle
    send_tick(4'd2,  1'b0, 1'b1, 1'b0, 32'd6005,       1'b0); // floor 1
    send_tick(4'd2,  1'b0, 1'b1, 1'b0, 32'd6006,       1'b0); // floor 2, open
    send_tick(4'd2,  1'b0, 1'b0, 1'b1, 32'd6007,       1'b0);
    send_tick(4'd0,  1'b0, 1'b0, 1'b0, 32'd6008,       1'b0); // call back down
    send_tick(4'd0,  1'b0, 1'b0, 1'b0, 32'd9008,       1'b0);
    send_tick(4'd0,  1'b0, 1'b0, 1'b1, 32'd9009,       1'b0); // heading down
    send_tick(4'd0,  1'b1, 1'b1, 1'b1, 32'd9010,       1'b0); // floor 1, door flags ignored
    send_tick(4'd0,  1'b0, 1'b1, 1'b0, 32'd9011,       1'b0); // floor 0, open
    send_tick(4'd0,  1'b0, 1'b0, 1'b0, 32'd9012,       1'b0); // still opening
    send_tick(4'd15, 1'b0, 1'b0, 1'b1, 32'd9013,       1'b0);
    send_tick(4'd15, 1'b1, 1'b1, 1'b1, 32'd9014,       1'b0); // top floor call
    clock_ms = 32'd9014;
    plan_target = 4'd15;

    run_phase(3000, 1'b0);
    write_door_wait('0);
    run_phase(0, 1'b0);
    write_door_wait(20'hFFFFF);
    run_phase(32'hFFFFF, 1'b1);
    write_door_wait(20'd1);
    run_phase(1, 1'b0);
    odd_wait = 20'($urandom_range(2, 6000));
    write_door_wait(odd_wait);
    run_phase(32'(odd_wait), 1'b0);
    write_door_wait(20'd3000);
    run_phase(3000, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("sent %0d ticks under %0d door wait settings, one %0d-cycle result hold-off",
             ticks_sent, settings_used, HOLD_OFF_CYCLES);
    $display("checked %0d result words, car state codes reached (bit per code): %b",
             checked_count, states_seen);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_elevator_car_door_sequencer passed");
    end else begin
      $display("tb_elevator_car_door_sequencer failed");
    end
    $finish;
  end

endmodule
